// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mer_pkg.sv =====
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_W = 12;
  localparam int OUT_W = 13;

endpackage

// ===== rtl/mer_mul.sv =====
module mer_mul import mer_pkg::*; #(
  parameter int A_W = 2 * RADIUS_BITS_DEF,
  parameter int B_W = 2 * RADIUS_BITS_DEF + 4
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   prod
);

  logic [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Channel | Direction | Ports
// request | in        | in_valid, in_stall, in_req_type, in_center_x/y, in_radius_x/y
// result  | out       | out_valid, out_stall, out_right_col, out_left_col,
//         |           | out_lower_row, out_upper_row, out_last_point
// A step: STEP2, CHK in region one; STEP2 in region two; final or idle steps stay in IDLE.
// A start request runs three products on the shared multiplier, then setup in ST4 and ST5.
// Entering region two adds chained products on the same multiplier, in states R2A to R2G.
// Reset is synchronous and active low; it leaves the block idle with no ellipse loaded.
// A request is taken only when the sequencer is idle and the result register is free
// or being emptied in the same cycle.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic signed [COORD_W-1:0]     in_center_x,
  input  logic signed [COORD_W-1:0]     in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_x,
  input  logic [RADIUS_BITS-1:0]        in_radius_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       out_right_col,
  output logic signed [OUT_W-1:0]       out_left_col,
  output logic signed [OUT_W-1:0]       out_lower_row,
  output logic signed [OUT_W-1:0]       out_upper_row,
  output logic                          out_last_point
);

  localparam int R   = RADIUS_BITS;
  localparam int XW  = R + 1;
  localparam int SQW = 2 * R;
  localparam int DW  = 4 * R + 8;
  localparam int AW  = 2 * R;
  localparam int BW  = 2 * R + 4;
  localparam int PW  = AW + BW;
  localparam int CW  = ((XW > OUT_W) ? XW : OUT_W) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ST1   = 4'd1;
  localparam logic [3:0] S_ST2   = 4'd2;
  localparam logic [3:0] S_ST3   = 4'd3;
  localparam logic [3:0] S_ST4   = 4'd4;
  localparam logic [3:0] S_ST5   = 4'd5;
  localparam logic [3:0] S_STEP2 = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_R2A   = 4'd8;
  localparam logic [3:0] S_R2B   = 4'd9;
  localparam logic [3:0] S_R2C   = 4'd10;
  localparam logic [3:0] S_R2D   = 4'd11;
  localparam logic [3:0] S_R2E   = 4'd12;
  localparam logic [3:0] S_R2F   = 4'd13;
  localparam logic [3:0] S_R2G   = 4'd14;

  logic [3:0]                state_r, state_nxt;
  logic                      busy_r, busy_nxt;
  logic                      second_r, second_nxt;
  logic                      br_r, br_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic [R-1:0]              rx_r, rx_nxt;
  logic [XW-1:0]             x_r, x_nxt;
  logic [R-1:0]              y_r, y_nxt;
  logic [SQW-1:0]            rx2_r, rx2_nxt;
  logic [SQW-1:0]            ry2_r, ry2_nxt;
  logic signed [DW-1:0]      px_r, px_nxt;
  logic signed [DW-1:0]      py_r, py_nxt;
  logic signed [DW-1:0]      d_r, d_nxt;
  logic signed [DW-1:0]      acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]   rc_r, rc_nxt;
  logic signed [OUT_W-1:0]   lc_r, lc_nxt;
  logic signed [OUT_W-1:0]   lr_r, lr_nxt;
  logic signed [OUT_W-1:0]   ur_r, ur_nxt;
  logic                      last_r, last_nxt;

  logic [AW-1:0]             mul_a;
  logic [BW-1:0]             mul_b;
  logic [PW-1:0]             prod;

  logic                      in_acc;
  logic                      last_pt;
  logic                      d_neg;
  logic                      d_pos;
  logic                      add_px;
  logic                      sub_py;
  logic signed [DW-1:0]      two_rx2;
  logic signed [DW-1:0]      two_ry2;
  logic signed [DW-1:0]      rx2_e;
  logic signed [DW-1:0]      ry2_e;
  logic signed [DW-1:0]      prod_e;
  logic signed [DW-1:0]      q_adj;
  logic signed [DW-1:0]      q_trunc;
  logic [XW:0]               tx;
  logic [R-1:0]              ym;
  logic [CW-1:0]             sum_rc;
  logic [CW-1:0]             sum_lc;
  logic [CW-1:0]             sum_lr;
  logic [CW-1:0]             sum_ur;

  mer_mul #(
    .A_W(AW),
    .B_W(BW)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign last_pt = second_r && (y_r == '0);
  assign d_neg   = d_r[DW-1];
  assign d_pos   = !d_r[DW-1] && (d_r != '0);
  assign add_px  = !second_r || !br_r;
  assign sub_py  = second_r || !br_r;
  assign two_rx2 = DW'({rx2_r, 1'b0});
  assign two_ry2 = DW'({ry2_r, 1'b0});
  assign rx2_e   = DW'(rx2_r);
  assign ry2_e   = DW'(ry2_r);
  assign prod_e  = DW'(prod);
  assign q_adj   = acc_r + (acc_r[DW-1] ? DW'(3) : DW'(0));
  assign q_trunc = {{2{q_adj[DW-1]}}, q_adj[DW-1:2]};
  assign tx      = {x_r, 1'b1};
  assign ym      = (y_r == '0) ? R'(1) : y_r - R'(1);

  assign sum_rc = CW'(cx_r) + CW'(x_r);
  assign sum_lc = CW'(cx_r) - CW'(x_r);
  assign sum_lr = CW'(cy_r) + CW'(y_r);
  assign sum_ur = CW'(cy_r) - CW'(y_r);

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    second_nxt    = second_r;
    br_nxt        = br_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx_nxt        = rx_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    rc_nxt        = rc_r;
    lc_nxt        = lc_r;
    lr_nxt        = lr_r;
    ur_nxt        = ur_r;
    last_nxt      = last_r;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_req_type) begin
            cx_nxt     = in_center_x;
            cy_nxt     = in_center_y;
            rx_nxt     = in_radius_x;
            x_nxt      = '0;
            y_nxt      = in_radius_y;
            px_nxt     = '0;
            second_nxt = 1'b0;
            busy_nxt   = 1'b1;
            state_nxt  = S_ST1;
          end else if (busy_r) begin
            out_valid_nxt = 1'b1;
            rc_nxt        = sum_rc[OUT_W-1:0];
            lc_nxt        = sum_lc[OUT_W-1:0];
            lr_nxt        = sum_lr[OUT_W-1:0];
            ur_nxt        = sum_ur[OUT_W-1:0];
            last_nxt      = last_pt;
            if (last_pt) begin
              busy_nxt   = 1'b0;
              second_nxt = 1'b0;
            end else begin
              state_nxt = S_STEP2;
              if (!second_r) begin
                x_nxt  = x_r + XW'(1);
                px_nxt = px_r + two_ry2;
                br_nxt = d_neg;
                if (!d_neg) begin
                  y_nxt  = y_r - R'(1);
                  py_nxt = py_r - two_rx2;
                end
              end else begin
                y_nxt  = y_r - R'(1);
                py_nxt = py_r - two_rx2;
                br_nxt = d_pos;
                if (!d_pos) begin
                  x_nxt  = x_r + XW'(1);
                  px_nxt = px_r + two_ry2;
                end
              end
            end
          end
        end
      end
      S_ST1: begin
        mul_a     = AW'(rx_r);
        mul_b     = BW'(rx_r);
        state_nxt = S_ST2;
      end
      S_ST2: begin
        rx2_nxt   = prod[SQW-1:0];
        mul_a     = AW'(y_r);
        mul_b     = BW'(y_r);
        state_nxt = S_ST3;
      end
      S_ST3: begin
        ry2_nxt   = prod[SQW-1:0];
        mul_a     = AW'(rx2_r);
        mul_b     = BW'(y_r);
        state_nxt = S_ST4;
      end
      S_ST4: begin
        py_nxt    = prod_e <<< 1;
        acc_nxt   = (ry2_e <<< 2) + rx2_e - (prod_e <<< 2);
        state_nxt = S_ST5;
      end
      S_ST5: begin
        d_nxt     = q_trunc;
        state_nxt = S_CHK;
      end
      S_STEP2: begin
        d_nxt = d_r + (second_r ? rx2_e : ry2_e) + (add_px ? px_r : DW'(0))
                - (sub_py ? py_r : DW'(0));
        state_nxt = second_r ? S_IDLE : S_CHK;
      end
      S_CHK: begin
        state_nxt = (px_r >= py_r) ? S_R2A : S_IDLE;
      end
      S_R2A: begin
        mul_a     = AW'(tx);
        mul_b     = BW'(tx);
        state_nxt = S_R2B;
      end
      S_R2B: begin
        mul_a     = AW'(ry2_r);
        mul_b     = prod[BW-1:0];
        state_nxt = S_R2C;
      end
      S_R2C: begin
        acc_nxt   = prod_e;
        mul_a     = AW'(ym);
        mul_b     = BW'(ym);
        state_nxt = S_R2D;
      end
      S_R2D: begin
        mul_a     = AW'(rx2_r);
        mul_b     = prod[BW-1:0];
        state_nxt = S_R2E;
      end
      S_R2E: begin
        acc_nxt   = acc_r + (prod_e <<< 2);
        mul_a     = AW'(rx2_r);
        mul_b     = BW'(ry2_r);
        state_nxt = S_R2F;
      end
      S_R2F: begin
        acc_nxt   = acc_r - (prod_e <<< 2);
        state_nxt = S_R2G;
      end
      S_R2G: begin
        d_nxt      = q_trunc;
        second_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    br_r   <= br_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    rx2_r  <= rx2_nxt;
    ry2_r  <= ry2_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    rc_r   <= rc_nxt;
    lc_r   <= lc_nxt;
    lr_r   <= lr_nxt;
    ur_r   <= ur_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_right_col  = rc_r;
  assign out_left_col   = lc_r;
  assign out_lower_row  = lr_r;
  assign out_upper_row  = ur_r;
  assign out_last_point = last_r;

`include "assert_macros.svh"

  `ASSERT_IMP(a_second_busy, clk, rst_n, second_r, busy_r,
              "region two flag set while idle")
  `ASSERT_NXT(a_start_seq, clk, rst_n, in_acc && !in_req_type,
              (state_r == S_ST1) && busy_r && !second_r, "start request did not begin setup")
  `ASSERT_NXT(a_r2_entry, clk, rst_n, state_r == S_R2G, second_r && (state_r == S_IDLE),
              "region two entry did not complete")
  `ASSERT_IMP(a_last_idle, clk, rst_n, out_valid_r && last_r, !busy_r,
              "ellipse still active after final set")

endmodule
